// ===== sv/udr_pkg.sv =====
`default_nettype none
package udr_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0] SID_READ = 8'h22;
  localparam logic [7:0] SID_SEC = 8'h27;
  localparam logic [7:0] SID_WRITE = 8'h2E;
  localparam logic [7:0] POS_OFFSET = 8'h40;
  localparam logic [7:0] NEG_SID = 8'h7F;
  localparam logic [7:0] NRC_LENGTH = 8'h13;
  localparam logic [7:0] NRC_IDENT = 8'h31;
  localparam logic [7:0] NRC_KEY = 8'h35;
  localparam logic [7:0] NRC_ACCESS = 8'h33;
  localparam logic [7:0] PAD_BYTE = 8'h55;
  localparam logic [7:0] SUB_SEED = 8'h01;
  localparam logic [7:0] SUB_KEY = 8'h02;
  localparam logic [7:0] LEN_READ = 8'h03;
  localparam logic [7:0] LEN_SEED = 8'h02;
  localparam logic [7:0] LEN_KEY = 8'h06;
  localparam logic [7:0] LEN_WRITE = 8'h05;

  localparam logic [31:0] SEED_RST = 32'h0108_8221;
  localparam logic [15:0] IDENT_RST = 16'h0123;
  localparam logic [15:0] READ_RST = 16'h0078;
  localparam logic [31:0] RELOCK_RST = 32'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED   = 2'd0,
    CFG_IDENT  = 2'd1,
    CFG_READ   = 2'd2,
    CFG_RELOCK = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte0;
    logic [7:0] rx_byte1;
    logic [7:0] rx_byte2;
    logic [7:0] rx_byte3;
    logic [7:0] rx_byte4;
    logic [7:0] rx_byte5;
    logic [7:0] rx_byte6;
    logic [7:0] rx_byte7;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte0;
    logic [7:0] tx_byte1;
    logic [7:0] tx_byte2;
    logic [7:0] tx_byte3;
    logic [7:0] tx_byte4;
    logic [7:0] tx_byte5;
    logic [7:0] tx_byte6;
    logic [7:0] tx_byte7;
    logic       unlocked;
  } out_item_t;

  typedef struct packed {
    logic [31:0] seed_value;
    logic [15:0] ident_value;
    logic [15:0] read_value;
    logic [31:0] relock_ticks;
  } cfg_t;

  typedef struct packed {
    logic        seed_given;
    logic        security_open;
    logic [31:0] relock_count;
  } sec_t;

endpackage
`default_nettype wire

// ===== sv/udr_cfg_regs.sv =====
`default_nettype none
module udr_cfg_regs
  import udr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED:   cfg_nxt.seed_value = cfg_wdata;
        CFG_IDENT:  cfg_nxt.ident_value = cfg_wdata[15:0];
        CFG_READ:   cfg_nxt.read_value = cfg_wdata[15:0];
        CFG_RELOCK: cfg_nxt.relock_ticks = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed_value <= SEED_RST;
      cfg_r.ident_value <= IDENT_RST;
      cfg_r.read_value <= READ_RST;
      cfg_r.relock_ticks <= RELOCK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== sv/udr_respond.sv =====
`default_nettype none
module udr_respond
  import udr_pkg::*;
(
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  sec_t      sec,
  output logic      answer,
  output out_item_t resp,
  output sec_t      sec_nxt
);

  logic [7:0]  s0, s1, s2, s3;
  logic        key_ok;
  logic        id_ok;
  logic [32:0] count_inc;

  assign s0 = cfg.seed_value[31:24];
  assign s1 = cfg.seed_value[23:16];
  assign s2 = cfg.seed_value[15:8];
  assign s3 = cfg.seed_value[7:0];

  assign key_ok = (item.rx_byte3 == (s0 ^ s1)) && (item.rx_byte4 == 8'(s1 + s2)) &&
                  (item.rx_byte5 == (s2 ^ s3)) && (item.rx_byte6 == 8'(s3 + s0));
  assign id_ok = {item.rx_byte2, item.rx_byte3} == cfg.ident_value;
  assign count_inc = {1'b0, sec.relock_count} + 33'd1;

  always_comb begin
    answer = 1'b0;
    sec_nxt = sec;
    resp.tx_byte0 = LEN_READ;
    resp.tx_byte1 = NEG_SID;
    resp.tx_byte2 = item.rx_byte1;
    resp.tx_byte3 = NRC_LENGTH;
    resp.tx_byte4 = PAD_BYTE;
    resp.tx_byte5 = PAD_BYTE;
    resp.tx_byte6 = PAD_BYTE;
    resp.tx_byte7 = PAD_BYTE;
    if (item.func) begin
      // tick: count toward relock while open
      if (sec.security_open) begin
        if (count_inc >= {1'b0, cfg.relock_ticks}) begin
          sec_nxt.security_open = 1'b0;
          sec_nxt.relock_count = '0;
        end else begin
          sec_nxt.relock_count = count_inc[31:0];
        end
      end
    end else begin
      unique case (item.rx_byte1)
        SID_READ: begin
          answer = 1'b1;
          if (item.rx_byte0 != LEN_READ) begin
            resp.tx_byte3 = NRC_LENGTH;
          end else if (!id_ok) begin
            resp.tx_byte3 = NRC_IDENT;
          end else begin
            resp.tx_byte0 = LEN_WRITE;
            resp.tx_byte1 = SID_READ + POS_OFFSET;
            resp.tx_byte2 = item.rx_byte2;
            resp.tx_byte3 = item.rx_byte3;
            resp.tx_byte4 = cfg.read_value[15:8];
            resp.tx_byte5 = cfg.read_value[7:0];
          end
        end
        SID_SEC: begin
          answer = 1'b1;
          if (item.rx_byte2 == SUB_SEED && item.rx_byte0 == LEN_SEED) begin
            resp.tx_byte0 = LEN_KEY;
            resp.tx_byte1 = SID_SEC + POS_OFFSET;
            resp.tx_byte2 = SUB_SEED;
            resp.tx_byte3 = s0;
            resp.tx_byte4 = s1;
            resp.tx_byte5 = s2;
            resp.tx_byte6 = s3;
            sec_nxt.seed_given = 1'b1;
          end else if (item.rx_byte2 == SUB_KEY && item.rx_byte0 == LEN_KEY) begin
            if (!key_ok) begin
              resp.tx_byte3 = NRC_KEY;
            end else if (sec.seed_given && !sec.security_open) begin
              sec_nxt.security_open = 1'b1;
              sec_nxt.seed_given = 1'b0;
              sec_nxt.relock_count = '0;
              resp.tx_byte0 = LEN_SEED;
              resp.tx_byte1 = SID_SEC + POS_OFFSET;
              resp.tx_byte2 = SUB_KEY;
              resp.tx_byte3 = PAD_BYTE;
            end else begin
              // valid key out of sequence: drop silently
              answer = 1'b0;
            end
          end else begin
            resp.tx_byte3 = NRC_LENGTH;
          end
        end
        SID_WRITE: begin
          answer = 1'b1;
          if (item.rx_byte0 != LEN_WRITE) begin
            resp.tx_byte3 = NRC_LENGTH;
          end else if (!id_ok) begin
            resp.tx_byte3 = NRC_IDENT;
          end else if (!sec.security_open) begin
            resp.tx_byte3 = NRC_ACCESS;
          end else begin
            resp.tx_byte1 = SID_WRITE + POS_OFFSET;
            resp.tx_byte2 = item.rx_byte2;
            resp.tx_byte3 = item.rx_byte3;
          end
        end
        default: answer = 1'b0;
      endcase
    end
    resp.unlocked = sec_nxt.security_open;
  end

endmodule
`default_nettype wire

// ===== sv/udr_sec_state.sv =====
`default_nettype none
module udr_sec_state
  import udr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic upd,
  input  sec_t      sec_nxt,
  output sec_t      sec
);

  sec_t sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0;
    end else if (upd) begin
      sec_r <= sec_nxt;
    end
  end

  assign sec = sec_r;

endmodule
`default_nettype wire

// ===== sv/uds_diag_responder_core.sv =====
`default_nettype none
// UDS diagnostic responder: takes one request frame or timer tick per cycle, unless
// in_stall is high, and answers read (0x22), security access (0x27) and write
// (0x2E) requests with at most one response frame each. An item is decoded
// against the security state in the input register and leaves through the
// result register; throughput is one item per cycle, limited only by out_stall.
// Ticks, unknown services and out-of-sequence valid keys produce no result.
// Configuration writes take effect on the next cycle and are expected only
// while the block is idle.
module uds_diag_responder_core
  import udr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  in_item_t                   in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  sec_t      sec;
  sec_t      sec_nxt;
  logic      answer;
  out_item_t resp;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      adv;
  logic      fire;

  udr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  udr_respond u_resp (
    .item    (in_item_r),
    .cfg     (cfg),
    .sec     (sec),
    .answer  (answer),
    .resp    (resp),
    .sec_nxt (sec_nxt)
  );

  udr_sec_state u_sec (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (fire),
    .sec_nxt (sec_nxt),
    .sec     (sec)
  );

  // advance the decode stage when the result register is free or being taken
  assign adv = !out_valid_r || !out_stall;
  assign fire = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= fire && answer;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (fire && answer) begin
      out_item_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

endmodule
`default_nettype wire

// ===== verif/uds_resp_checker.sv =====
`timescale 1ns / 1ps
module uds_resp_checker
  import udr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           errors,
  output int unsigned           pending
);

  typedef logic [0:7][7:0] frame_t;

  logic [31:0] seed_r;
  logic [15:0] ident_r;
  logic [15:0] read_r;
  logic [31:0] relock_r;
  logic        seed_given;
  logic        sec_open;
  logic [31:0] relock_cnt;
  out_item_t   resp_due[$];

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic frame_t neg_frame(input logic [7:0] sid, input logic [7:0] code);
    return {8'd3, NEG_SID, sid, code, {4{PAD_BYTE}}};
  endfunction

  // Advance the security state for one transfer and queue the response it causes.
  task automatic decode_request(input in_item_t rq);
    frame_t          fr;
    logic [0:3][7:0] s;
    logic [0:3][7:0] k;
    logic [32:0]     nxt;
    logic            answer;
    fr = '0;
    answer = 1'b0;
    s = seed_r;
    k = {s[0] ^ s[1], s[1] + s[2], s[2] ^ s[3], s[3] + s[0]};
    if (rq.func) begin
      if (sec_open) begin
        nxt = {1'b0, relock_cnt} + 33'd1;
        // a zero limit compares like one
        if (nxt >= {1'b0, relock_r}) begin
          sec_open = 1'b0;
          relock_cnt = '0;
        end else begin
          relock_cnt = nxt[31:0];
        end
      end
    end else begin
      answer = 1'b1;
      case (rq.rx_byte1)
        SID_READ: begin
          if (rq.rx_byte0 != LEN_READ) fr = neg_frame(SID_READ, NRC_LENGTH);
          else if ({rq.rx_byte2, rq.rx_byte3} != ident_r) fr = neg_frame(SID_READ, NRC_IDENT);
          else fr = {8'd5, SID_READ + POS_OFFSET, rq.rx_byte2, rq.rx_byte3, read_r,
                     {2{PAD_BYTE}}};
        end
        SID_SEC: begin
          if (rq.rx_byte2 == SUB_SEED && rq.rx_byte0 == LEN_SEED) begin
            fr = {8'd6, SID_SEC + POS_OFFSET, SUB_SEED, s, PAD_BYTE};
            seed_given = 1'b1;
          end else if (rq.rx_byte2 == SUB_KEY && rq.rx_byte0 == LEN_KEY) begin
            if ({rq.rx_byte3, rq.rx_byte4, rq.rx_byte5, rq.rx_byte6} != k) begin
              fr = neg_frame(SID_SEC, NRC_KEY);
            end else if (seed_given && !sec_open) begin
              sec_open = 1'b1;
              seed_given = 1'b0;
              relock_cnt = '0;
              fr = {8'd2, SID_SEC + POS_OFFSET, SUB_KEY, {5{PAD_BYTE}}};
            end else begin
              // good key out of sequence: silently dropped
              answer = 1'b0;
            end
          end else begin
            fr = neg_frame(SID_SEC, NRC_LENGTH);
          end
        end
        SID_WRITE: begin
          if (rq.rx_byte0 != LEN_WRITE) fr = neg_frame(SID_WRITE, NRC_LENGTH);
          else if ({rq.rx_byte2, rq.rx_byte3} != ident_r) fr = neg_frame(SID_WRITE, NRC_IDENT);
          else if (!sec_open) fr = neg_frame(SID_WRITE, NRC_ACCESS);
          else fr = {8'd3, SID_WRITE + POS_OFFSET, rq.rx_byte2, rq.rx_byte3, {4{PAD_BYTE}}};
        end
        default: answer = 1'b0;
      endcase
    end
    if (answer) resp_due.push_back(out_item_t'({fr, sec_open}));
  endtask

  task automatic check_response(input out_item_t got);
    out_item_t want;
    frame_t    gf;
    frame_t    wf;
    int        i;
    if (resp_due.size() == 0) begin
      report($sformatf("response %h with none outstanding", got));
    end else begin
      want = resp_due.pop_front();
      gf = got[64:1];
      wf = want[64:1];
      for (i = 0; i < 8; i++) begin
        if (gf[i] !== wf[i])
          report($sformatf("tx_byte%0d got %02h, want %02h", i, gf[i], wf[i]));
      end
      if (got.unlocked !== want.unlocked)
        report($sformatf("unlocked got %b, want %b", got.unlocked, want.unlocked));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_r = SEED_RST;
      ident_r = IDENT_RST;
      read_r = READ_RST;
      relock_r = RELOCK_RST;
      seed_given = 1'b0;
      sec_open = 1'b0;
      relock_cnt = '0;
      resp_due.delete();
    end else begin
      // retire the older transfer first
      if (out_valid && !out_stall) check_response(out_item);
      if (in_valid && !in_stall) decode_request(in_item);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED:   seed_r = cfg_wdata;
          CFG_IDENT:  ident_r = cfg_wdata[15:0];
          CFG_READ:   read_r = cfg_wdata[15:0];
          CFG_RELOCK: relock_r = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending <= resp_due.size();
  end

endmodule

// ===== verif/uds_diag_responder_core_test.sv =====
`timescale 1ns / 1ps
module uds_diag_responder_core_test;
  import udr_pkg::*;

  localparam int unsigned PHASE_ITEMS = 500;
  localparam int unsigned DRAIN = 6;
  localparam int unsigned HOLD_LEN = 300;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SEED;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int unsigned           errors;
  int unsigned           pending;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_cnt = 0;
  logic [31:0] cur_seed = SEED_RST;
  logic [15:0] cur_ident = IDENT_RST;

  uds_diag_responder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  uds_resp_checker watch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: one long hold-off once requested, random stalls otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_go && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #2_400_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_item_t frame(input logic [7:0] len, input logic [7:0] sid,
                                     input logic [7:0] b2, input logic [7:0] b3,
                                     input logic [31:0] tail = '0);
    return {1'b0, len, sid, b2, b3, tail};
  endfunction

  function automatic logic [31:0] key_of(input logic [31:0] sd);
    logic [0:3][7:0] s;
    s = sd;
    return {s[0] ^ s[1], s[1] + s[2], s[2] ^ s[3], s[3] + s[0]};
  endfunction

  function automatic in_item_t key_frame();
    logic [31:0] k;
    k = key_of(cur_seed);
    return frame(LEN_KEY, SID_SEC, SUB_KEY, k[31:24], {k[23:0], 8'($urandom)});
  endfunction

  function automatic logic [15:0] pick_ident();
    return ($urandom_range(3) != 0) ? cur_ident : 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_len(input logic [7:0] good);
    return ($urandom_range(9) != 0) ? good : 8'($urandom);
  endfunction

  function automatic in_item_t rand_request();
    in_item_t    it;
    logic [31:0] k;
    int unsigned r;
    it = {1'($urandom), 32'($urandom), 32'($urandom)};
    r = $urandom_range(99);
    if (r < 12) begin
      it.func = 1'b1;
    end else begin
      it.func = 1'b0;
      if (r < 30) begin
        it.rx_byte0 = pick_len(LEN_READ);
        it.rx_byte1 = SID_READ;
        {it.rx_byte2, it.rx_byte3} = pick_ident();
      end else if (r < 42) begin
        it.rx_byte0 = pick_len(LEN_SEED);
        it.rx_byte1 = SID_SEC;
        if ($urandom_range(9) != 0) it.rx_byte2 = SUB_SEED;
      end else if (r < 58) begin
        k = key_of(cur_seed);
        if ($urandom_range(2) == 0) k = k ^ (32'h1 << $urandom_range(31));
        it.rx_byte0 = pick_len(LEN_KEY);
        it.rx_byte1 = SID_SEC;
        it.rx_byte2 = SUB_KEY;
        {it.rx_byte3, it.rx_byte4, it.rx_byte5, it.rx_byte6} = k;
      end else if (r < 82) begin
        it.rx_byte0 = pick_len(LEN_WRITE);
        it.rx_byte1 = SID_WRITE;
        {it.rx_byte2, it.rx_byte3} = pick_ident();
      end else if (r < 90) begin
        it.rx_byte1 = SID_SEC;
      end
    end
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every response is back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] seed, input logic [15:0] ident,
                           input logic [15:0] rd, input logic [31:0] relock);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEED;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_index <= CFG_IDENT;
    cfg_wdata <= {16'h0, ident};
    @(posedge clk);
    cfg_index <= CFG_READ;
    cfg_wdata <= {16'h0, rd};
    @(posedge clk);
    cfg_index <= CFG_RELOCK;
    cfg_wdata <= relock;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_seed = seed;
    cur_ident = ident;
  endtask

  task automatic run_phase(input int unsigned count);
    in_item_t    it;
    int unsigned n;
    int unsigned w;
    n = 0;
    while (n < count) begin
      if ($urandom_range(4) == 0) begin
        // full unlock sequence followed by writes
        offer(frame(LEN_SEED, SID_SEC, SUB_SEED, 8'($urandom), $urandom));
        offer(key_frame());
        w = $urandom_range(3, 1);
        repeat (w)
          offer(frame(LEN_WRITE, SID_WRITE, cur_ident[15:8], cur_ident[7:0], $urandom));
        n += w + 2;
      end else begin
        it = rand_request();
        offer(it);
        if (it.func || (it.rx_byte1 inside {SID_READ, SID_SEC, SID_WRITE})) n++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values out of reset
    offer(frame(LEN_READ, SID_READ, IDENT_RST[15:8], IDENT_RST[7:0]));
    offer(frame(8'h00, SID_READ, IDENT_RST[15:8], IDENT_RST[7:0]));
    offer(frame(LEN_READ, SID_READ, IDENT_RST[15:8], ~IDENT_RST[7:0]));
    offer(frame(LEN_WRITE, SID_WRITE, IDENT_RST[15:8], IDENT_RST[7:0], 32'hFFFF_FFFF));
    offer(frame(8'hFF, SID_WRITE, IDENT_RST[15:8], IDENT_RST[7:0]));
    offer(frame(LEN_WRITE, SID_WRITE, 8'h00, 8'h00));
    offer(key_frame());
    offer(frame(LEN_SEED, SID_SEC, SUB_SEED, 8'h00));
    offer(frame(8'd3, SID_SEC, SUB_SEED, 8'h00));
    offer(frame(LEN_SEED, SID_SEC, 8'h00, 8'h00));
    offer(frame(LEN_KEY, SID_SEC, SUB_KEY, 8'h00, 32'h0));
    offer(frame(8'd5, SID_SEC, SUB_KEY, 8'h00));
    offer(key_frame());
    offer(key_frame());
    offer(frame(LEN_WRITE, SID_WRITE, IDENT_RST[15:8], IDENT_RST[7:0]));
    offer({1'b1, 64'hFFFF_FFFF_FFFF_FFFF});
    offer({1'b0, 64'hFFFF_FFFF_FFFF_FFFF});
    settle();

    // all-ones registers, relock limit of zero
    load_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0);
    offer(frame(LEN_SEED, SID_SEC, SUB_SEED, 8'hFF));
    offer(key_frame());
    offer(frame(LEN_READ, SID_READ, 8'hFF, 8'hFF));
    offer({1'b1, 64'h0});
    offer(frame(LEN_WRITE, SID_WRITE, 8'hFF, 8'hFF));
    settle();

    // all-zero registers, relock limit at its maximum
    load_regs(32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF);
    offer(frame(LEN_SEED, SID_SEC, SUB_SEED, 8'h00));
    offer(key_frame());
    offer(frame(LEN_WRITE, SID_WRITE, 8'h00, 8'h00));
    settle();

    // no idling, with one long receiver hold-off at the start
    load_regs($urandom, 16'($urandom), 16'($urandom), $urandom_range(12, 1));
    hold_go <= 1'b1;
    run_phase(PHASE_ITEMS);
    settle();

    load_regs($urandom, 16'($urandom), 16'($urandom), $urandom_range(12, 1));
    idle_pct = 61;
    run_phase(PHASE_ITEMS);
    settle();

    load_regs($urandom, 16'($urandom), 16'($urandom), $urandom_range(12, 1));
    idle_pct = 0;
    stall_pct <= 61;
    run_phase(PHASE_ITEMS);
    settle();

    load_regs($urandom, 16'($urandom), 16'($urandom), 32'd1);
    idle_pct = 22;
    stall_pct <= 22;
    run_phase(PHASE_ITEMS);
    settle();

    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
